// File: rtl/mfq_pkg.sv
// ----------------------------------------------------------------------------
// mfq_pkg
// Shared constants, codes and types for the multilevel feedback queue
// scheduler.
// ----------------------------------------------------------------------------
package mfq_pkg;

  localparam int LEVELS      = 3;
  localparam int QUEUE_DEPTH = 16;

  localparam int LVL_W  = $clog2(LEVELS);
  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int SLOTS  = LEVELS * QUEUE_DEPTH;
  localparam int ADDR_W = $clog2(SLOTS);

  localparam int ID_W      = 16;
  localparam int BURST_W   = 16;
  localparam int QUANT_W   = 16;
  localparam int TIME_W    = 32;
  localparam int STATUS_W  = 2;
  localparam int OUT_LVL_W = 2;
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;

  // result status codes
  typedef logic [STATUS_W-1:0] status_t;
  localparam status_t STS_RUN   = 2'd0;
  localparam status_t STS_IDLE  = 2'd1;
  localparam status_t STS_ADDED = 2'd2;
  localparam status_t STS_FULL  = 2'd3;

  // item modes
  localparam logic MODE_ADD      = 1'b0;
  localparam logic MODE_DISPATCH = 1'b1;

  // register word index (paddr[3:2])
  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_QUANTUM_TOP    = 2'd0;
  localparam reg_idx_t REG_QUANTUM_MIDDLE = 2'd1;
  localparam reg_idx_t REG_QUANTUM_BOTTOM = 2'd2;

  // one queue entry
  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [BURST_W-1:0] remaining;
    logic               started;
  } slot_t;

  // flat memory address of entry ptr in queue lv
  function automatic logic [ADDR_W-1:0] slot_addr(input logic [LVL_W-1:0] lv,
                                                  input logic [PTR_W-1:0] ptr);
    return ADDR_W'(lv) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(ptr);
  endfunction

endpackage

// File: rtl/mfq_ram.sv
// ----------------------------------------------------------------------------
// mfq_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module mfq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/multilevel_feedback_queue_scheduler_core.sv
// ----------------------------------------------------------------------------
// multilevel_feedback_queue_scheduler_core
// Three-level feedback-queue scheduler with per-level time quanta.
// ----------------------------------------------------------------------------
// Each accepted item gives exactly one result. An add (mode 0) puts a process
// at the tail of the top queue and reports added, or rejected when that queue
// is full; it completes once the output register is free. A dispatch (mode 1)
// pops the head of the highest non-empty queue, runs it for the smaller of its
// remaining time and that level's quantum, and then drops it (finished),
// demotes it one level, or requeues it on its own level when it is already at
// the bottom or the lower queue is full. A dispatch passes through a read
// state, the registered read of the queue memory; with nothing queued it
// reports idle without that read. The next item is taken in the cycle the
// current one completes, so adds run at one per cycle while results are not
// stalled, and no dispatch overlaps the next item. The result sits in an
// output register, so a stalled result does not block the next transfer in,
// only its completion. Quanta are written through the APB port (top at 0x0,
// middle at 0x4, bottom at 0x8, low 16 bits kept) and should only be changed
// while the block is idle. Scheduler time is 32 bits and wraps.
// ----------------------------------------------------------------------------
module multilevel_feedback_queue_scheduler_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_mode,
  input  logic [mfq_pkg::ID_W-1:0]              in_process_id,
  input  logic [mfq_pkg::BURST_W-1:0]           in_burst_time,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [mfq_pkg::STATUS_W-1:0]          out_status,
  output logic [mfq_pkg::ID_W-1:0]              out_run_id,
  output logic [mfq_pkg::TIME_W-1:0]            out_slice_start,
  output logic [mfq_pkg::BURST_W-1:0]           out_slice_length,
  output logic [mfq_pkg::OUT_LVL_W-1:0]         out_level,
  output logic                                  out_finished,
  output logic                                  out_first_run,
  // configuration (APB)
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [mfq_pkg::PADDR_W-1:0]           paddr,
  input  logic [mfq_pkg::PDATA_W-1:0]           pwdata,
  output logic [mfq_pkg::PDATA_W-1:0]           prdata,
  output logic                                  pready
);

  // sequencer states
  localparam logic [1:0] ST_EMPTY = 2'd0;  // no item held
  localparam logic [1:0] ST_EXEC  = 2'd1;  // item in input register
  localparam logic [1:0] ST_READ  = 2'd2;  // dispatch, head entry being read

  localparam int LEVELS = mfq_pkg::LEVELS;
  localparam int LVL_W  = mfq_pkg::LVL_W;
  localparam int PTR_W  = mfq_pkg::PTR_W;
  localparam int CNT_W  = mfq_pkg::CNT_W;

  localparam int OUT_LVL_W_EXT = mfq_pkg::OUT_LVL_W + LVL_W;

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  logic [1:0]                    state_r, state_nxt;
  logic                          mode_r;
  logic [mfq_pkg::ID_W-1:0]      pid_r;
  logic [mfq_pkg::BURST_W-1:0]   burst_r;
  logic [LVL_W-1:0]              lvl_r;

  logic [PTR_W-1:0]              head_r  [LEVELS];
  logic [PTR_W-1:0]              tail_r  [LEVELS];
  logic [CNT_W-1:0]              count_r [LEVELS];
  logic [PTR_W-1:0]              head_nxt  [LEVELS];
  logic [PTR_W-1:0]              tail_nxt  [LEVELS];
  logic [CNT_W-1:0]              count_nxt [LEVELS];

  logic [mfq_pkg::TIME_W-1:0]    time_r;
  logic [mfq_pkg::QUANT_W-1:0]   q_top_r, q_mid_r, q_bot_r;

  logic                          out_valid_r;
  mfq_pkg::status_t              out_status_r;
  logic [mfq_pkg::ID_W-1:0]      out_run_id_r;
  logic [mfq_pkg::TIME_W-1:0]    out_start_r;
  logic [mfq_pkg::BURST_W-1:0]   out_len_r;
  logic [mfq_pkg::OUT_LVL_W-1:0] out_level_r;
  logic                          out_finished_r;
  logic                          out_first_r;

  // --------------------------------------------------------------------------
  // Control
  // --------------------------------------------------------------------------
  logic                          accept;
  logic                          out_free;
  logic                          exec_add, exec_disp, in_read;
  logic                          any_ready;
  logic [LVL_W-1:0]              sel_lv;
  logic [PTR_W-1:0]              head_sel;
  logic                          add_room;
  logic                          add_commit, idle_commit, run_commit, requeue;
  logic                          finish;
  logic                          lower_room;
  logic [LVL_W-1:0]              push_lv;
  logic [PTR_W-1:0]              tail_push;

  // slice evaluation
  mfq_pkg::slot_t                rd_slot;
  mfq_pkg::slot_t                requeue_slot;
  mfq_pkg::slot_t                add_slot;
  logic [mfq_pkg::QUANT_W-1:0]   quantum;
  logic                          done;
  logic [mfq_pkg::BURST_W-1:0]   slice_len;
  logic [OUT_LVL_W_EXT-1:0]      lvl_ext;

  // memory port
  logic                          ram_wr_en;
  logic [mfq_pkg::ADDR_W-1:0]    ram_wr_addr;
  mfq_pkg::slot_t                ram_wr_data;
  logic                          ram_rd_en;
  logic [mfq_pkg::ADDR_W-1:0]    ram_rd_addr;
  logic [$bits(mfq_pkg::slot_t)-1:0] ram_rd_data;

  logic                          cfg_wr;
  mfq_pkg::reg_idx_t             cfg_idx;

  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign exec_add  = (state_r == ST_EXEC) && (mode_r == mfq_pkg::MODE_ADD);
  assign exec_disp = (state_r == ST_EXEC) && (mode_r == mfq_pkg::MODE_DISPATCH);
  assign in_read   = (state_r == ST_READ);

  // highest non-empty level and its head pointer
  always_comb begin
    any_ready = 1'b0;
    sel_lv    = '0;
    for (int l = LEVELS - 1; l >= 0; l--) begin
      if (count_r[l] != '0) begin
        any_ready = 1'b1;
        sel_lv    = LVL_W'(l);
      end
    end
  end

  always_comb begin
    head_sel = '0;
    for (int l = 0; l < LEVELS; l++) begin
      if (LVL_W'(l) == sel_lv) begin
        head_sel = head_r[l];
      end
    end
  end

  assign add_room    = (count_r[0] != CNT_W'(mfq_pkg::QUEUE_DEPTH));
  assign add_commit  = exec_add && out_free && add_room;
  assign idle_commit = exec_disp && !any_ready && out_free;
  assign run_commit  = in_read && out_free;
  assign finish      = (exec_add && out_free) || idle_commit || run_commit;

  // a new item comes in as soon as the current one completes
  assign in_stall = !((state_r == ST_EMPTY) || finish);

  // --------------------------------------------------------------------------
  // Slice: quantum of the popped level, length and completion
  // --------------------------------------------------------------------------
  assign rd_slot = mfq_pkg::slot_t'(ram_rd_data);

  always_comb begin
    if (lvl_r == '0) begin
      quantum = q_top_r;
    end else if (lvl_r == LVL_W'(LEVELS - 1)) begin
      quantum = q_bot_r;
    end else begin
      quantum = q_mid_r;
    end
  end

  assign done      = (rd_slot.remaining <= quantum);
  assign slice_len = done ? rd_slot.remaining : quantum;
  assign requeue   = run_commit && !done;

  // demote if there is a lower level with room, else back on own level
  always_comb begin
    lower_room = 1'b0;
    for (int l = 1; l < LEVELS; l++) begin
      if ((LVL_W'(l - 1) == lvl_r) && (count_r[l] != CNT_W'(mfq_pkg::QUEUE_DEPTH))) begin
        lower_room = 1'b1;
      end
    end
  end

  assign push_lv = lower_room ? (lvl_r + LVL_W'(1)) : lvl_r;

  always_comb begin
    tail_push = '0;
    for (int l = 0; l < LEVELS; l++) begin
      if (LVL_W'(l) == push_lv) begin
        tail_push = tail_r[l];
      end
    end
  end

  assign requeue_slot.id        = rd_slot.id;
  assign requeue_slot.remaining = rd_slot.remaining - slice_len;
  assign requeue_slot.started   = 1'b1;

  assign add_slot.id        = pid_r;
  assign add_slot.remaining = burst_r;
  assign add_slot.started   = 1'b0;

  // --------------------------------------------------------------------------
  // Queue memory
  // --------------------------------------------------------------------------
  assign ram_rd_en   = exec_disp && any_ready;
  assign ram_rd_addr = mfq_pkg::slot_addr(sel_lv, head_sel);
  assign ram_wr_en   = add_commit || requeue;
  assign ram_wr_addr = add_commit ? mfq_pkg::slot_addr('0, tail_r[0])
                                  : mfq_pkg::slot_addr(push_lv, tail_push);
  assign ram_wr_data = add_commit ? add_slot : requeue_slot;

  mfq_ram #(
    .WIDTH ($bits(mfq_pkg::slot_t)),
    .DEPTH (mfq_pkg::SLOTS)
  ) u_queue_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // --------------------------------------------------------------------------
  // Per-level pointer and count update
  // --------------------------------------------------------------------------
  always_comb begin
    for (int l = 0; l < LEVELS; l++) begin
      logic pop, push;
      pop  = run_commit && (LVL_W'(l) == lvl_r);
      push = (requeue && (LVL_W'(l) == push_lv)) || (add_commit && (l == 0));
      head_nxt[l]  = head_r[l];
      tail_nxt[l]  = tail_r[l];
      count_nxt[l] = count_r[l];
      if (pop) begin
        head_nxt[l] = (head_r[l] == PTR_W'(mfq_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                     : head_r[l] + PTR_W'(1);
      end
      if (push) begin
        tail_nxt[l] = (tail_r[l] == PTR_W'(mfq_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                     : tail_r[l] + PTR_W'(1);
      end
      if (push && !pop) begin
        count_nxt[l] = count_r[l] + CNT_W'(1);
      end else if (pop && !push) begin
        count_nxt[l] = count_r[l] - CNT_W'(1);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    if (accept) begin
      state_nxt = ST_EXEC;
    end else if (finish) begin
      state_nxt = ST_EMPTY;
    end else if (ram_rd_en) begin
      state_nxt = ST_READ;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_EMPTY;
      time_r  <= '0;
      for (int l = 0; l < LEVELS; l++) begin
        head_r[l]  <= '0;
        tail_r[l]  <= '0;
        count_r[l] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (run_commit) begin
        time_r <= time_r + mfq_pkg::TIME_W'(slice_len);
      end
      for (int l = 0; l < LEVELS; l++) begin
        head_r[l]  <= head_nxt[l];
        tail_r[l]  <= tail_nxt[l];
        count_r[l] <= count_nxt[l];
      end
    end
  end

  // input register and the level latched for the read cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r  <= in_mode;
      pid_r   <= in_process_id;
      burst_r <= in_burst_time;
    end
    if (ram_rd_en) begin
      lvl_r <= sel_lv;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  assign lvl_ext = OUT_LVL_W_EXT'(lvl_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_run_id_r   <= '0;
      out_start_r    <= '0;
      out_len_r      <= '0;
      out_level_r    <= '0;
      out_finished_r <= 1'b0;
      out_first_r    <= 1'b0;
      if (run_commit) begin
        out_status_r   <= mfq_pkg::STS_RUN;
        out_run_id_r   <= rd_slot.id;
        out_start_r    <= time_r;
        out_len_r      <= slice_len;
        out_level_r    <= lvl_ext[mfq_pkg::OUT_LVL_W-1:0];
        out_finished_r <= done;
        out_first_r    <= !rd_slot.started;
      end else if (idle_commit) begin
        out_status_r <= mfq_pkg::STS_IDLE;
      end else if (add_room) begin
        out_status_r <= mfq_pkg::STS_ADDED;
      end else begin
        out_status_r <= mfq_pkg::STS_FULL;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_run_id       = out_run_id_r;
  assign out_slice_start  = out_start_r;
  assign out_slice_length = out_len_r;
  assign out_level        = out_level_r;
  assign out_finished     = out_finished_r;
  assign out_first_run    = out_first_r;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_top_r <= mfq_pkg::QUANT_W'(1);
      q_mid_r <= mfq_pkg::QUANT_W'(2);
      q_bot_r <= mfq_pkg::QUANT_W'(4);
    end else if (cfg_wr) begin
      case (cfg_idx)
        mfq_pkg::REG_QUANTUM_TOP:    q_top_r <= pwdata[mfq_pkg::QUANT_W-1:0];
        mfq_pkg::REG_QUANTUM_MIDDLE: q_mid_r <= pwdata[mfq_pkg::QUANT_W-1:0];
        mfq_pkg::REG_QUANTUM_BOTTOM: q_bot_r <= pwdata[mfq_pkg::QUANT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      mfq_pkg::REG_QUANTUM_TOP:    prdata = mfq_pkg::PDATA_W'(q_top_r);
      mfq_pkg::REG_QUANTUM_MIDDLE: prdata = mfq_pkg::PDATA_W'(q_mid_r);
      mfq_pkg::REG_QUANTUM_BOTTOM: prdata = mfq_pkg::PDATA_W'(q_bot_r);
      default:                     prdata = '0;
    endcase
  end

endmodule

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the three-level feedback-queue scheduler. Adds and
// dispatches are pushed through the input channel with random gaps and result
// stalls. A software copy of the scheduler predicts every result, and each
// result transfer is checked against the oldest prediction. Quanta are
// rewritten over APB between phases, only once the block has gone quiet.
// ----------------------------------------------------------------------------
module testbench;
  import mfq_pkg::*;

  // APB word 3 has no register behind it; writes there must be dropped
  localparam reg_idx_t REG_SPARE = 2'd3;
  // cycles without any transfer before the run is declared hung
  localparam int STALL_LIMIT = 2000;
  localparam int MAX_REPORTS = 10;

  // one result as seen on the out_ channel
  typedef struct packed {
    status_t              status;
    logic [ID_W-1:0]      run_id;
    logic [TIME_W-1:0]    slice_start;
    logic [BURST_W-1:0]   slice_length;
    logic [OUT_LVL_W-1:0] level;
    logic                 finished;
    logic                 first_run;
  } slice_rec_t;

  // --------------------------------------------------------------------------
  // Scheduler shadow: keeps its own queues, time and quanta, predicts the
  // result of every accepted item and checks results in order.
  // --------------------------------------------------------------------------
  class schedule_tracker;
    slot_t               queue_mem [LEVELS][QUEUE_DEPTH];
    int unsigned         head [LEVELS];
    int unsigned         tail [LEVELS];
    int unsigned         fill [LEVELS];
    logic [TIME_W-1:0]   sched_time;
    logic [QUANT_W-1:0]  q_top, q_mid, q_bot;
    slice_rec_t          pending_slices [$];
    int                  mismatches, items_taken, results_checked;
    int                  n_slices, n_finished, n_held, n_idle, n_full, n_zero_len;

    function new();
      for (int lv = 0; lv < LEVELS; lv++) begin
        head[lv] = 0;
        tail[lv] = 0;
        fill[lv] = 0;
      end
      sched_time = '0;
      q_top = 16'd1;
      q_mid = 16'd2;
      q_bot = 16'd4;
    endfunction

    // only the low 16 bits are kept; unmapped words are dropped
    function void set_quantum(reg_idx_t idx, logic [PDATA_W-1:0] value);
      case (idx)
        REG_QUANTUM_TOP:    q_top = value[QUANT_W-1:0];
        REG_QUANTUM_MIDDLE: q_mid = value[QUANT_W-1:0];
        REG_QUANTUM_BOTTOM: q_bot = value[QUANT_W-1:0];
        default: ;
      endcase
    endfunction

    function bit push_slot(int lv, slot_t s);
      if (fill[lv] >= QUEUE_DEPTH) return 1'b0;
      queue_mem[lv][tail[lv]] = s;
      tail[lv] = (tail[lv] + 1) % QUEUE_DEPTH;
      fill[lv]++;
      return 1'b1;
    endfunction

    function void take_item(logic mode, logic [ID_W-1:0] pid,
                            logic [BURST_W-1:0] burst);
      slice_rec_t         r;
      slot_t              s;
      int                 lv;
      logic [QUANT_W-1:0] q;
      bit                 demoted;
      r = '0;
      items_taken++;
      if (mode == MODE_ADD) begin
        s.id        = pid;
        s.remaining = burst;
        s.started   = 1'b0;
        r.status    = push_slot(0, s) ? STS_ADDED : STS_FULL;
        if (r.status == STS_FULL) n_full++;
      end else begin
        lv = 0;
        while (lv < LEVELS && fill[lv] == 0) lv++;
        if (lv == LEVELS) begin
          r.status = STS_IDLE;
          n_idle++;
        end else begin
          s = queue_mem[lv][head[lv]];
          head[lv] = (head[lv] + 1) % QUEUE_DEPTH;
          fill[lv]--;
          q = (lv == 0) ? q_top : (lv == LEVELS - 1) ? q_bot : q_mid;
          r.status       = STS_RUN;
          r.run_id       = s.id;
          r.slice_start  = sched_time;
          r.finished     = (s.remaining <= q);
          r.slice_length = r.finished ? s.remaining : q;
          r.level        = OUT_LVL_W'(lv);
          r.first_run    = !s.started;
          sched_time     = sched_time + TIME_W'(r.slice_length);
          n_slices++;
          if (r.finished) n_finished++;
          if (r.slice_length == 0) n_zero_len++;
          if (!r.finished) begin
            s.remaining = s.remaining - r.slice_length;
            s.started   = 1'b1;
            // drop a level; if the lower queue is full, stay put at the tail
            demoted = (lv + 1 < LEVELS) ? push_slot(lv + 1, s) : 1'b0;
            if (!demoted) begin
              if (lv + 1 < LEVELS) n_held++;
              void'(push_slot(lv, s));
            end
          end
        end
      end
      pending_slices = {pending_slices, r};
    endfunction

    function void report(string what, slice_rec_t want, slice_rec_t got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%s: expected sts=%0d id=%h start=%h len=%h lvl=%0d fin=%b first=%b",
                 what, want.status, want.run_id, want.slice_start,
                 want.slice_length, want.level, want.finished, want.first_run,
                 "\n    got      sts=%0d id=%h start=%h len=%h lvl=%0d fin=%b first=%b",
                 got.status, got.run_id, got.slice_start, got.slice_length,
                 got.level, got.finished, got.first_run);
    endfunction

    function void match_result(slice_rec_t got);
      slice_rec_t want;
      results_checked++;
      if (pending_slices.size() == 0) begin
        report("unexpected result", '0, got);
        return;
      end
      want = pending_slices[0];
      pending_slices.delete(0);
      if (got !== want) report("result mismatch", want, got);
    endfunction

    function int outstanding();
      return pending_slices.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_mode = MODE_ADD;
  logic [ID_W-1:0]       in_process_id = '0;
  logic [BURST_W-1:0]    in_burst_time = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [STATUS_W-1:0]   out_status;
  logic [ID_W-1:0]       out_run_id;
  logic [TIME_W-1:0]     out_slice_start;
  logic [BURST_W-1:0]    out_slice_length;
  logic [OUT_LVL_W-1:0]  out_level;
  logic                  out_finished;
  logic                  out_first_run;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [PADDR_W-1:0]    paddr = '0;
  logic [PDATA_W-1:0]    pwdata = '0;
  logic [PDATA_W-1:0]    prdata;
  logic                  pready;

  // calm: no sender gaps and no result stalls for the closing stretch
  bit                    calm = 1'b0;
  int                    quiet_cycles = 0;
  schedule_tracker       tracker = new();

  always #1 clk = ~clk;

  multilevel_feedback_queue_scheduler_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_process_id    (in_process_id),
    .in_burst_time    (in_burst_time),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_run_id       (out_run_id),
    .out_slice_start  (out_slice_start),
    .out_slice_length (out_slice_length),
    .out_level        (out_level),
    .out_finished     (out_finished),
    .out_first_run    (out_first_run),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // --------------------------------------------------------------------------
  // Result side: random stall bursts between free-running stretches of
  // varying length. Driven on the falling edge, like every other input.
  // --------------------------------------------------------------------------
  initial begin
    forever begin
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                          : $urandom_range(1, 8)) @(negedge clk);
      if (!calm) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  // result transfers are checked at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
      tracker.match_result('{status:       out_status,
                             run_id:       out_run_id,
                             slice_start:  out_slice_start,
                             slice_length: out_slice_length,
                             level:        out_level,
                             finished:     out_finished,
                             first_run:    out_first_run});
  end

  // watchdog: counts cycles in which neither channel moves a transfer
  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
               quiet_cycles, tracker.outstanding());
      $display("testbench: FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // one input transfer; valid is held and payload frozen while stalled
  task automatic offer_item(input logic mode, input logic [ID_W-1:0] pid,
                            input logic [BURST_W-1:0] burst);
    int gap;
    gap = (!calm && $urandom_range(0, 5) == 0) ? $urandom_range(1, 12) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      = 1'b1;
    in_mode       = mode;
    in_process_id = pid;
    in_burst_time = burst;
    do @(posedge clk); while (in_stall !== 1'b0);
    tracker.take_item(mode, pid, burst);
  endtask

  task automatic add_item(input logic [ID_W-1:0] pid, input logic [BURST_W-1:0] burst);
    offer_item(MODE_ADD, pid, burst);
  endtask

  // payload is don't-care on a dispatch, so it is scrambled
  task automatic dispatch_item();
    offer_item(MODE_DISPATCH, ID_W'($urandom_range(0, 65535)),
               BURST_W'($urandom_range(0, 65535)));
  endtask

  // mostly short bursts so processes finish; now and then the full range
  function automatic logic [BURST_W-1:0] pick_burst();
    return ($urandom_range(0, 15) == 0) ? BURST_W'($urandom_range(0, 65535))
                                        : BURST_W'($urandom_range(0, 12));
  endfunction

  // sender holds off until every result is back, then lets the pipe empty
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle until pready
  task automatic write_quantum(input reg_idx_t idx, input logic [PDATA_W-1:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = PADDR_W'({idx, 2'b00});
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    tracker.set_quantum(idx, value);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Random traffic in episodes: add-heavy, balanced and dispatch-heavy runs
  // let the queues fill and drain; a flood episode fills the top queue, pushes
  // it all down into the middle one and refills the top, so that demotion
  // meets a full lower queue.
  task automatic random_items(input int count);
    int done_items, kind, len, add_pct;
    done_items = 0;
    while (done_items < count) begin
      kind = $urandom_range(0, 5);
      if (kind == 5) begin
        repeat (QUEUE_DEPTH)
          add_item(ID_W'($urandom_range(0, 65535)), BURST_W'($urandom_range(3, 40)));
        repeat (QUEUE_DEPTH) dispatch_item();
        repeat (QUEUE_DEPTH)
          add_item(ID_W'($urandom_range(0, 65535)), BURST_W'($urandom_range(3, 40)));
        repeat (4) dispatch_item();
        done_items += 3 * QUEUE_DEPTH + 4;
      end else begin
        add_pct = (kind < 2) ? 85 : (kind < 4) ? 50 : 20;
        len     = $urandom_range(8, 48);
        repeat (len) begin
          if ($urandom_range(0, 99) < add_pct)
            add_item(ID_W'($urandom_range(0, 65535)), pick_burst());
          else
            dispatch_item();
        end
        done_items += len;
      end
    end
  endtask

  task automatic run_phase(input logic [PDATA_W-1:0] q_top_w, q_mid_w, q_bot_w,
                           input int count);
    settle();
    write_quantum(REG_QUANTUM_TOP, q_top_w);
    write_quantum(REG_QUANTUM_MIDDLE, q_mid_w);
    write_quantum(REG_QUANTUM_BOTTOM, q_bot_w);
    random_items(count);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed, with the reset quanta (1, 2, 4)
    dispatch_item();                          // nothing queued: idle
    add_item(16'h0000, 16'h0000);             // zero burst
    dispatch_item();                          // runs for nothing, finished
    add_item(16'hFFFF, 16'hFFFF);             // widest id and burst
    for (int i = 1; i < QUEUE_DEPTH; i++)
      add_item((i % 2) ? 16'h5555 : 16'hAAAA ^ 16'(i), 16'($urandom_range(1, 6)));
    add_item(16'h1234, 16'h0001);             // top queue full: rejected
    repeat (4) dispatch_item();               // first slices, demotion

    run_phase(32'd1, 32'd1, 32'd1, 350);
    // unmapped word and upper bits of pwdata must both be ignored
    settle();
    write_quantum(REG_SPARE, 32'h0000_0009);
    run_phase(32'hFFFF_0000, 32'h0000_0000, 32'h8001_0000, 150);
    run_phase(32'h0000_FFFF, 32'h0000_FFFF, 32'h0000_FFFF, 300);
    run_phase($urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(1, 8), 400);
    run_phase($urandom, $urandom, $urandom, 300);
    settle();
    calm = 1'b1;
    run_phase(32'd2, 32'd3, 32'd5, 400);

    settle();
    $display("covered %0d items, %0d results: %0d slices (%0d finished, %0d of zero length)",
             tracker.items_taken, tracker.results_checked, tracker.n_slices,
             tracker.n_finished, tracker.n_zero_len);
    $display("  %0d idle dispatches, %0d rejected adds, %0d demotions held back, %0d mismatches",
             tracker.n_idle, tracker.n_full, tracker.n_held, tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.outstanding() == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule

// File: sim.f
rtl/mfq_pkg.sv
rtl/mfq_ram.sv
rtl/multilevel_feedback_queue_scheduler_core.sv
bench/testbench.sv
